// ===== hdl/chkv_pkg.sv =====
// shared types and constants of the chained hash key-value table
package chkv_pkg;

  localparam int unsigned KEY_W   = 64;
  localparam int unsigned VAL_W   = 64;
  localparam int unsigned OP_W    = 2;
  localparam int unsigned STAT_W  = 2;
  localparam int unsigned COUNT_W = 11;
  localparam int unsigned BC_W    = 9;
  localparam int unsigned DIGIT_W = 4;
  localparam int unsigned APB_DW  = 32;
  localparam int unsigned APB_AW  = 3;

  // the spare code is handled as a lookup
  typedef enum logic [OP_W-1:0] {
    OP_LOOKUP = 2'd0,
    OP_INSERT = 2'd1,
    OP_DELETE = 2'd2,
    OP_SPARE  = 2'd3
  } chkv_op_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK          = 2'd0,
    ST_OVERWRITTEN = 2'd1,
    ST_NOT_FOUND   = 2'd2,
    ST_FULL        = 2'd3
  } chkv_status_e;

  localparam logic REG_BUCKET_COUNT = 1'b0;
  localparam logic [BC_W-1:0] BC_RESET = 9'd256;

endpackage

// ===== hdl/chkv_if.sv =====
// request and response channel interfaces
interface chkv_req_if
  import chkv_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [OP_W-1:0]     opcode;
  logic [KEY_W-1:0]    key;
  logic [VAL_W-1:0]    value;

  modport source (output valid, opcode, key, value, input ready);
  modport sink   (input valid, opcode, key, value, output ready);
endinterface

interface chkv_rsp_if
  import chkv_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [STAT_W-1:0]   status;
  logic [VAL_W-1:0]    found_value;
  logic [COUNT_W-1:0]  entry_count;

  modport source (output valid, status, found_value, entry_count, input ready);
  modport sink   (input valid, status, found_value, entry_count, output ready);
endinterface

// ===== hdl/chkv_ram.sv =====
// simple dual-port synchronous ram with registered read data
module chkv_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/chkv_mod.sv =====
// iterative key modulo bucket count, one digit per cycle
module chkv_mod
  import chkv_pkg::*;
#(
  parameter int unsigned DW = 9
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [KEY_W-1:0] dividend_i,
  input  logic [DW-1:0]    divisor_i,
  output logic             done_o,
  output logic [DW-1:0]    rem_o
);

  localparam int unsigned STEPS = KEY_W / DIGIT_W;
  localparam int unsigned CW = $clog2(STEPS);
  localparam logic [CW-1:0] LAST = CW'(STEPS - 1);

  logic             busy_q, done_q;
  logic [CW-1:0]    cnt_q;
  logic [KEY_W-1:0] dvd_q;
  logic [DW-1:0]    dsr_q;
  logic [DW-1:0]    rem_q, rem_d;

  always_comb begin
    logic [DW:0] t;
    rem_d = rem_q;
    for (int i = 0; i < DIGIT_W; i++) begin
      t = {rem_d, dvd_q[KEY_W-1-i]};
      if (t >= {1'b0, dsr_q}) begin
        t = t - {1'b0, dsr_q};
      end
      rem_d = t[DW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == LAST) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      dsr_q <= divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      dvd_q <= dvd_q << DIGIT_W;
      rem_q <= rem_d;
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

// ===== hdl/chained_hash_key_value_table.sv =====
// chained hash key-value table: bucket heads and node pool in synchronous rams
// operation: accept, key modulo, bucket head read, chain walk node by node, then an
//   update (with an extra allocate step when a freed node is reused) and the response;
//   one transaction at a time
// reset: a clearing pass over all MAX_BUCKETS bucket heads empties them, no request
//   is taken meanwhile; configuration writes are taken at any time
module chained_hash_key_value_table
  import chkv_pkg::*;
#(
  parameter int unsigned MAX_BUCKETS = 256,
  parameter int unsigned POOL_NODES  = 1024
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  chkv_req_if.sink          req_i,
  chkv_rsp_if.source        rsp_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  localparam int unsigned HAW = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
  localparam int unsigned DW  = $clog2(MAX_BUCKETS + 1);
  localparam int unsigned NAW = $clog2(POOL_NODES);
  localparam int unsigned LW  = $clog2(POOL_NODES + 1);
  localparam logic [LW-1:0]  NIL      = LW'(POOL_NODES);
  localparam logic [HAW-1:0] HEAD_END = HAW'(MAX_BUCKETS - 1);

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_DIV, S_HEAD, S_WALK, S_RESOLVE, S_ALLOC, S_DONE
  } state_e;

  state_e state_q;

  // configuration
  logic [BC_W-1:0] bc_q;
  logic [DW-1:0]   eff_buckets;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_BUCKET_COUNT) ? APB_DW'(bc_q) : '0;

  always_comb begin
    if (bc_q == '0) begin
      eff_buckets = DW'(1);
    end else if (32'(bc_q) > MAX_BUCKETS) begin
      eff_buckets = DW'(MAX_BUCKETS);
    end else begin
      eff_buckets = DW'(bc_q);
    end
  end

  // request and walk registers
  logic [OP_W-1:0]   op_q;
  logic [KEY_W-1:0]  key_q;
  logic [VAL_W-1:0]  val_q;
  logic [HAW-1:0]    bucket_q, clr_q;
  logic [LW-1:0]     head_q, cur_q, prev_q, hit_next_q;
  logic [VAL_W-1:0]  hit_val_q;
  logic              hit_q;
  logic [LW-1:0]     count_q, fresh_q, sp_q;
  logic [STAT_W-1:0] res_status_q;
  logic [VAL_W-1:0]  res_found_q;
  logic              rsp_valid_q;
  logic [STAT_W-1:0] rsp_status_q;
  logic [VAL_W-1:0]  rsp_found_q;
  logic [COUNT_W-1:0] rsp_count_q;

  // modulo unit
  logic          div_start, div_done;
  logic [DW-1:0] div_rem;

  chkv_mod #(.DW(DW)) u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (req_i.key),
    .divisor_i  (eff_buckets),
    .done_o     (div_done),
    .rem_o      (div_rem)
  );

  // memories
  logic            head_we, head_re;
  logic [HAW-1:0]  head_waddr, head_raddr;
  logic [LW-1:0]   head_wdata, head_rd;
  logic            node_re, key_we, val_we, next_we, stk_we, stk_re;
  logic [NAW-1:0]  node_raddr, key_waddr, val_waddr, next_waddr, stk_waddr, stk_raddr;
  logic [KEY_W-1:0] key_rd;
  logic [VAL_W-1:0] val_wdata, val_rd;
  logic [LW-1:0]   next_wdata, next_rd;
  logic [NAW-1:0]  stk_rd, new_node;

  chkv_ram #(.WIDTH(LW), .DEPTH(MAX_BUCKETS)) u_head (
    .clk_i(clk_i), .we_i(head_we), .waddr_i(head_waddr), .wdata_i(head_wdata),
    .re_i(head_re), .raddr_i(head_raddr), .rdata_o(head_rd)
  );
  chkv_ram #(.WIDTH(KEY_W), .DEPTH(POOL_NODES)) u_key (
    .clk_i(clk_i), .we_i(key_we), .waddr_i(key_waddr), .wdata_i(key_q),
    .re_i(node_re), .raddr_i(node_raddr), .rdata_o(key_rd)
  );
  chkv_ram #(.WIDTH(VAL_W), .DEPTH(POOL_NODES)) u_val (
    .clk_i(clk_i), .we_i(val_we), .waddr_i(val_waddr), .wdata_i(val_wdata),
    .re_i(node_re), .raddr_i(node_raddr), .rdata_o(val_rd)
  );
  chkv_ram #(.WIDTH(LW), .DEPTH(POOL_NODES)) u_next (
    .clk_i(clk_i), .we_i(next_we), .waddr_i(next_waddr), .wdata_i(next_wdata),
    .re_i(node_re), .raddr_i(node_raddr), .rdata_o(next_rd)
  );
  // stack of nodes given back by delete; never-used nodes come from fresh_q
  chkv_ram #(.WIDTH(NAW), .DEPTH(POOL_NODES)) u_stack (
    .clk_i(clk_i), .we_i(stk_we), .waddr_i(stk_waddr), .wdata_i(cur_q[NAW-1:0]),
    .re_i(stk_re), .raddr_i(stk_raddr), .rdata_o(stk_rd)
  );

  logic is_insert, is_delete, do_link, do_overwrite, do_unlink, full;
  logic key_hit;

  assign is_insert = (op_q == OP_INSERT);
  assign is_delete = (op_q == OP_DELETE);
  assign full      = (count_q >= NIL);
  assign key_hit   = (key_rd == key_q);

  assign do_overwrite = (state_q == S_RESOLVE) && is_insert && hit_q;
  assign do_unlink    = (state_q == S_RESOLVE) && is_delete && hit_q;
  assign do_link      = ((state_q == S_RESOLVE) && is_insert && !hit_q && !full &&
                         (sp_q == '0)) || (state_q == S_ALLOC);
  assign new_node     = (state_q == S_ALLOC) ? stk_rd : fresh_q[NAW-1:0];

  assign div_start = (state_q == S_IDLE) && req_i.valid;
  assign req_i.ready = (state_q == S_IDLE);

  always_comb begin
    head_we    = 1'b0;
    head_waddr = bucket_q;
    head_wdata = NIL;
    if (state_q == S_CLEAR) begin
      head_we    = 1'b1;
      head_waddr = clr_q;
    end else if (do_link) begin
      head_we    = 1'b1;
      head_wdata = LW'(new_node);
    end else if (do_unlink && !(prev_q < NIL)) begin
      head_we    = 1'b1;
      head_wdata = hit_next_q;
    end
  end

  assign head_re    = (state_q == S_DIV) && div_done;
  assign head_raddr = div_rem[HAW-1:0];

  always_comb begin
    node_re    = 1'b0;
    node_raddr = head_rd[NAW-1:0];
    if (state_q == S_HEAD) begin
      node_re = (head_rd < NIL);
    end else if (state_q == S_WALK) begin
      node_re    = !key_hit && (next_rd < NIL);
      node_raddr = next_rd[NAW-1:0];
    end
  end

  assign key_we    = do_link;
  assign key_waddr = new_node;
  assign val_we    = do_link || do_overwrite;
  assign val_waddr = do_link ? new_node : cur_q[NAW-1:0];
  assign val_wdata = val_q;

  always_comb begin
    next_we    = 1'b0;
    next_waddr = new_node;
    next_wdata = head_q;
    if (do_link) begin
      next_we = 1'b1;
    end else if (do_unlink && (prev_q < NIL)) begin
      next_we    = 1'b1;
      next_waddr = prev_q[NAW-1:0];
      next_wdata = hit_next_q;
    end
  end

  assign stk_we    = do_unlink;
  assign stk_waddr = sp_q[NAW-1:0];
  assign stk_re    = (state_q == S_RESOLVE) && is_insert && !hit_q && !full &&
                     (sp_q != '0);
  assign stk_raddr = NAW'(sp_q - 1'b1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLEAR;
      clr_q        <= '0;
      bc_q         <= BC_RESET;
      count_q      <= '0;
      fresh_q      <= '0;
      sp_q         <= '0;
      hit_q        <= 1'b0;
      rsp_valid_q  <= 1'b0;
      op_q         <= '0;
      key_q        <= '0;
      val_q        <= '0;
      bucket_q     <= '0;
      head_q       <= '0;
      cur_q        <= '0;
      prev_q       <= '0;
      hit_next_q   <= '0;
      hit_val_q    <= '0;
      res_status_q <= '0;
      res_found_q  <= '0;
      rsp_status_q <= '0;
      rsp_found_q  <= '0;
      rsp_count_q  <= '0;
    end else begin
      if (psel && penable && pwrite && (paddr[2] == REG_BUCKET_COUNT)) begin
        bc_q <= pwdata[BC_W-1:0];
      end
      // in S_DONE the response register is reloaded below instead
      if (rsp_valid_q && rsp_o.ready && (state_q != S_DONE)) begin
        rsp_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_CLEAR: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == HEAD_END) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (req_i.valid) begin
            op_q    <= req_i.opcode;
            key_q   <= req_i.key;
            val_q   <= req_i.value;
            state_q <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_done) begin
            bucket_q <= div_rem[HAW-1:0];
            state_q  <= S_HEAD;
          end
        end
        S_HEAD: begin
          head_q <= head_rd;
          cur_q  <= head_rd;
          prev_q <= NIL;
          hit_q  <= 1'b0;
          state_q <= (head_rd < NIL) ? S_WALK : S_RESOLVE;
        end
        S_WALK: begin
          if (key_hit) begin
            hit_q      <= 1'b1;
            hit_val_q  <= val_rd;
            hit_next_q <= next_rd;
            state_q    <= S_RESOLVE;
          end else begin
            prev_q <= cur_q;
            cur_q  <= next_rd;
            if (!(next_rd < NIL)) begin
              state_q <= S_RESOLVE;
            end
          end
        end
        S_RESOLVE: begin
          res_found_q  <= '0;
          res_status_q <= ST_NOT_FOUND;
          state_q      <= S_DONE;
          if (is_insert) begin
            if (hit_q) begin
              res_status_q <= ST_OVERWRITTEN;
            end else if (full) begin
              res_status_q <= ST_FULL;
            end else if (sp_q != '0) begin
              state_q <= S_ALLOC;
            end else begin
              fresh_q      <= fresh_q + 1'b1;
              count_q      <= count_q + 1'b1;
              res_status_q <= ST_OK;
            end
          end else if (is_delete) begin
            if (hit_q) begin
              res_found_q  <= hit_val_q;
              res_status_q <= ST_OK;
              count_q      <= count_q - 1'b1;
              sp_q         <= sp_q + 1'b1;
            end
          end else if (hit_q) begin
            res_found_q  <= hit_val_q;
            res_status_q <= ST_OK;
          end
        end
        S_ALLOC: begin
          sp_q         <= sp_q - 1'b1;
          count_q      <= count_q + 1'b1;
          res_status_q <= ST_OK;
          state_q      <= S_DONE;
        end
        S_DONE: begin
          if (!rsp_valid_q || rsp_o.ready) begin
            rsp_valid_q  <= 1'b1;
            rsp_status_q <= res_status_q;
            rsp_found_q  <= res_found_q;
            rsp_count_q  <= COUNT_W'(count_q);
            state_q      <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign rsp_o.valid       = rsp_valid_q;
  assign rsp_o.status      = rsp_status_q;
  assign rsp_o.found_value = rsp_found_q;
  assign rsp_o.entry_count = rsp_count_q;

endmodule

// ===== tb/testbench.sv =====
// testbench of the chained hash key-value table: queued driver, monitor and table predictor
`timescale 1ns / 1ps
module testbench;
  import chkv_pkg::*;

  localparam int unsigned NBKT = 256;
  localparam int unsigned NPOOL = 1024;
  localparam int unsigned NIL = NPOOL;
  localparam int unsigned CYCLE_LIMIT = 1000000;

  typedef struct packed {
    logic [OP_W-1:0]  opcode;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
  } request_t;

  typedef struct packed {
    chkv_status_e       status;
    logic [VAL_W-1:0]   found_value;
    logic [COUNT_W-1:0] entry_count;
  } response_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [APB_AW-1:0] paddr = '0;
  logic [APB_DW-1:0] pwdata = '0;
  logic [APB_DW-1:0] prdata;
  logic pready;

  chkv_req_if req_if ();
  chkv_rsp_if rsp_if ();

  chained_hash_key_value_table u_top (
    .clk_i(clk_i), .rst_ni(rst_ni), .req_i(req_if.sink), .rsp_o(rsp_if.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // predictor copy of the table
  logic [BC_W-1:0]    pred_bc;
  int unsigned        pred_head[NBKT];
  logic [KEY_W-1:0]   pred_key[NPOOL];
  logic [VAL_W-1:0]   pred_val[NPOOL];
  int unsigned        pred_next[NPOOL];
  int unsigned        pred_free[NPOOL];
  int unsigned        pred_count;

  request_t  pending_reqs[$];
  response_t expected_rsps[$];
  logic [KEY_W-1:0] key_pool[$];
  int unsigned mismatches = 0;
  int unsigned cycles = 0;
  int unsigned hold_cycles = 0;

  function automatic response_t table_apply(request_t r);
    response_t o;
    int unsigned nb, bkt, prev, cur, steps, n;
    bit hit;
    nb = 32'(pred_bc);
    if (nb == 0) nb = 1;
    if (nb > NBKT) nb = NBKT;
    bkt = 32'(r.key % 64'(nb));
    prev = NIL;
    cur = pred_head[bkt];
    steps = 0;
    hit = 0;
    o.status = ST_NOT_FOUND;
    o.found_value = '0;
    while (cur < NPOOL && steps < NPOOL) begin
      if (pred_key[cur] == r.key) begin
        hit = 1;
        break;
      end
      prev = cur;
      cur = pred_next[cur];
      steps++;
    end
    if (r.opcode == OP_INSERT) begin
      if (hit) begin
        pred_val[cur] = r.value;
        o.status = ST_OVERWRITTEN;
      end else if (pred_count >= NPOOL) begin
        o.status = ST_FULL;
      end else begin
        n = pred_free[pred_count];
        pred_key[n] = r.key;
        pred_val[n] = r.value;
        pred_next[n] = pred_head[bkt];
        pred_head[bkt] = n;
        pred_count++;
        o.status = ST_OK;
      end
    end else if (r.opcode == OP_DELETE) begin
      if (hit && pred_count > 0) begin
        if (prev < NPOOL) pred_next[prev] = pred_next[cur];
        else pred_head[bkt] = pred_next[cur];
        o.found_value = pred_val[cur];
        pred_count--;
        pred_free[pred_count] = cur;
        o.status = ST_OK;
      end
    end else begin
      if (hit) begin
        o.found_value = pred_val[cur];
        o.status = ST_OK;
      end
    end
    o.entry_count = pred_count[COUNT_W-1:0];
    return o;
  endfunction

  function automatic int unsigned gap_len();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 40) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // input transactions are taken at the rising edge
  bit in_taken = 1'b0;
  always @(posedge clk_i) begin
    if (rst_ni && req_if.valid && req_if.ready) begin
      expected_rsps.push_back(table_apply(pending_reqs.pop_front()));
      in_taken = 1'b1;
    end
  end

  // driver
  int unsigned send_gap = 0;
  initial begin
    req_if.valid = 1'b0;
    req_if.opcode = '0;
    req_if.key = '0;
    req_if.value = '0;
  end
  always @(negedge clk_i) begin
    if (in_taken) begin
      in_taken = 1'b0;
      send_gap = gap_len();
    end
    if (send_gap > 0) begin
      send_gap--;
      req_if.valid <= 1'b0;
    end else if (pending_reqs.size() > 0) begin
      req_if.valid <= 1'b1;
      req_if.opcode <= pending_reqs[0].opcode;
      req_if.key <= pending_reqs[0].key;
      req_if.value <= pending_reqs[0].value;
    end else begin
      req_if.valid <= 1'b0;
    end
  end

  // sink ready with random stalls and an optional long hold-off
  int unsigned rdy_gap = 0;
  initial rsp_if.ready = 1'b0;
  always @(negedge clk_i) begin
    if (hold_cycles > 0) begin
      hold_cycles--;
      rsp_if.ready <= 1'b0;
    end else if (rdy_gap > 0) begin
      rdy_gap--;
      rsp_if.ready <= 1'b0;
    end else begin
      rsp_if.ready <= 1'b1;
      rdy_gap = ($urandom_range(0, 3) == 0) ? gap_len() : 0;
    end
  end

  // monitor
  always @(posedge clk_i) begin
    response_t exp_r;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      if (expected_rsps.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected response status=%0d", rsp_if.status);
      end else begin
        exp_r = expected_rsps.pop_front();
        if (rsp_if.status !== exp_r.status || rsp_if.found_value !== exp_r.found_value ||
            rsp_if.entry_count !== exp_r.entry_count) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp st=%0d val=%h cnt=%0d got st=%0d val=%h cnt=%0d",
                     exp_r.status, exp_r.found_value, exp_r.entry_count,
                     rsp_if.status, rsp_if.found_value, rsp_if.entry_count);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic wait_idle();
    while (pending_reqs.size() > 0 || expected_rsps.size() > 0 || req_if.valid)
      @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_bucket_count(logic [BC_W-1:0] v);
    @(negedge clk_i);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= '0; pwdata <= APB_DW'(v);
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    pred_bc = v;
    @(negedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic logic [KEY_W-1:0] pick_key();
    logic [KEY_W-1:0] k;
    if (key_pool.size() > 0 && $urandom_range(0, 3) != 0)
      return key_pool[$urandom_range(0, key_pool.size() - 1)];
    k = ($urandom_range(0, 1) == 0) ? 64'($urandom_range(0, 2000)) : rand64();
    key_pool.push_back(k);
    return k;
  endfunction

  task automatic push_req(logic [OP_W-1:0] op, logic [KEY_W-1:0] k, logic [VAL_W-1:0] v);
    request_t r;
    r.opcode = op; r.key = k; r.value = v;
    pending_reqs.push_back(r);
  endtask

  task automatic random_phase(int unsigned n);
    logic [OP_W-1:0] op;
    for (int unsigned i = 0; i < n; i++) begin
      case ($urandom_range(0, 9)) inside
        [0:3]: op = OP_INSERT;
        [4:6]: op = OP_LOOKUP;
        [7:8]: op = OP_DELETE;
        default: op = OP_SPARE;
      endcase
      push_req(op, pick_key(), rand64());
    end
  endtask

  initial begin
    pred_bc = BC_RESET;
    pred_count = 0;
    for (int i = 0; i < NBKT; i++) pred_head[i] = NIL;
    for (int i = 0; i < NPOOL; i++) begin
      pred_key[i] = '0; pred_val[i] = '0; pred_next[i] = NIL; pred_free[i] = i;
    end
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: extremes, every opcode, chains in one bucket
    push_req(OP_LOOKUP, '0, '0);
    push_req(OP_DELETE, '1, '0);
    push_req(OP_INSERT, '0, '1);
    push_req(OP_INSERT, '1, 64'h5555_5555_5555_5555);
    push_req(OP_INSERT, 64'd256, 64'hAAAA_AAAA_AAAA_AAAA);
    push_req(OP_INSERT, 64'd512, 64'h1234);
    push_req(OP_INSERT, 64'd256, 64'h4321);
    push_req(OP_LOOKUP, 64'd256, 64'h0);
    push_req(OP_SPARE, '1, '1);
    push_req(OP_DELETE, 64'd512, '0);
    push_req(OP_LOOKUP, 64'd0, '0);
    push_req(OP_DELETE, 64'd0, '0);
    push_req(OP_DELETE, 64'd0, '0);
    push_req(OP_LOOKUP, 64'd256, '0);
    wait_idle();

    // sender pauses until everything drained, then receiver long hold-off
    hold_cycles = 400;
    random_phase(30);
    wait_idle();

    write_bucket_count(9'd1);
    random_phase(60);
    wait_idle();
    write_bucket_count(9'd0);
    random_phase(30);
    wait_idle();
    write_bucket_count(9'h1FF);
    random_phase(60);
    wait_idle();
    write_bucket_count(9'd7);
    random_phase(60);
    wait_idle();
    write_bucket_count(9'd256);
    random_phase(60);
    wait_idle();

    // bulk inserts with small chains spread over many buckets
    write_bucket_count(9'd64);
    for (int i = 0; i < 150; i++) push_req(OP_INSERT, 64'(100000 + i), rand64());
    push_req(OP_INSERT, 64'd99999, '1);
    for (int i = 0; i < 20; i++) push_req(OP_DELETE, 64'(100000 + i), '0);
    random_phase(30);
    wait_idle();

    if (mismatches == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end
endmodule

// ===== chained_hash_key_value_table.f =====
hdl/chkv_pkg.sv
hdl/chkv_if.sv
hdl/chkv_ram.sv
hdl/chkv_mod.sv
hdl/chained_hash_key_value_table.sv
tb/testbench.sv
